// ===== rtl/core/mcpq_pkg.sv =====
// Shared types, sizes and codes for the min-count priority queue.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package mcpq_pkg;

  localparam int DEPTH   = 256;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int FILL_W  = $clog2(DEPTH + 1);
  localparam int TAG_W   = 9;
  localparam int COUNT_W = 32;
  localparam int OCC_W   = 9;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_POP    = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  // One word read back from the store during a scan
  typedef struct packed {
    logic             vld;
    logic             is_last;
    logic [IDX_W-1:0] idx;
    entry_t           ent;
  } scan_smp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WRITE,
    S_POP_RD,
    S_POP_CAP,
    S_SCAN,
    S_DRAIN,
    S_SWAP_LAST,
    S_SWAP_BEST,
    S_FINISH
  } state_t;

endpackage

// ===== rtl/core/min_count_priority_queue.sv =====
// Top level of the min-count priority queue: sequencer, fill level and result register.
// Depends on mcpq_pkg, mcpq_store and mcpq_min_unit.
//
//  channel | dir | handshake         | word
//  s_*     | in  | s_tvalid/s_tready | tuser: action; tdata: item_tag, item_count
//  m_*     | out | m_tvalid/m_tready | tuser: status; tdata: out_tag, out_count, occupancy,
//          |     |                   |        now_empty
//
// An insert appends the new word and a pop reads out the last word; then the occupied words
// are scanned, one store read per cycle feeding the shared compare unit, and up to two store
// writes move the minimum into the last slot. A pop that empties the queue skips the scan,
// and a refused operation goes straight to the finish state.
// Reset empties the queue at once; the store itself is not cleared.
// s_tready is low while an operation runs; a result that m_tready holds off keeps
// the block in its finish state until the word is taken.
`timescale 1ns / 1ps

module min_count_priority_queue
  import mcpq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // [8:0] item_tag, [40:9] item_count, [47:41] zero
  input  logic [0:0]  s_tuser,   // [0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [8:0] out_tag, [40:9] out_count, [49:41] occupancy,
                                 // [50] now_empty, [55:51] zero
  output logic [1:0]  m_tuser    // [1:0] status
);

  state_t state, state_next;

  logic [FILL_W-1:0] fill, fill_next;
  logic [IDX_W-1:0]  cnt, cnt_next;
  logic [FILL_W-1:0] fill_dec;
  logic [IDX_W-1:0]  last_idx;

  entry_t     new_ent;
  status_t    res_status;
  entry_t     res_ent;
  logic       res_load_acc;
  logic       res_load_pop;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;

  scan_smp_t        smp;
  logic             smp_vld;
  logic             smp_last;
  logic [IDX_W-1:0] smp_idx;
  logic [IDX_W-1:0] best_idx;
  entry_t           best_ent;
  entry_t           last_ent;

  logic             in_acc;
  logic             out_load;

  logic [TAG_W-1:0]   o_tag;
  logic [COUNT_W-1:0] o_count;
  logic [OCC_W-1:0]   o_occ;
  logic               o_empty;
  status_t            o_status;

  assign s_tready = (state == S_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign fill_dec = fill - FILL_W'(1);
  assign last_idx = fill_dec[IDX_W-1:0];

  mcpq_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mcpq_min_unit u_min (
    .clk      (clk),
    .smp      (smp),
    .best_idx (best_idx),
    .best_ent (best_ent),
    .last_ent (last_ent)
  );

  always_comb begin
    state_next   = state;
    fill_next    = fill;
    cnt_next     = cnt;
    wr_en        = 1'b0;
    wr_addr      = last_idx;
    wr_data      = new_ent;
    rd_en        = 1'b0;
    rd_addr      = cnt;
    res_load_acc = 1'b0;
    res_load_pop = 1'b0;
    out_load     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          res_load_acc = 1'b1;
          if (s_tuser[0] == ACT_INSERT) begin
            if (fill == FILL_W'(DEPTH)) begin
              state_next = S_FINISH;
            end else begin
              fill_next  = fill + FILL_W'(1);
              state_next = S_WRITE;
            end
          end else begin
            if (fill == '0) begin
              state_next = S_FINISH;
            end else begin
              fill_next  = fill_dec;
              state_next = S_POP_RD;
            end
          end
        end
      end
      S_WRITE: begin
        // append the new word at the last occupied slot
        wr_en      = 1'b1;
        cnt_next   = '0;
        state_next = S_SCAN;
      end
      S_POP_RD: begin
        rd_en      = 1'b1;
        rd_addr    = fill[IDX_W-1:0];
        state_next = S_POP_CAP;
      end
      S_POP_CAP: begin
        res_load_pop = 1'b1;
        cnt_next     = '0;
        state_next   = (fill == '0) ? S_FINISH : S_SCAN;
      end
      S_SCAN: begin
        rd_en = 1'b1;
        if (cnt == last_idx) begin
          state_next = S_DRAIN;
        end else begin
          cnt_next = cnt + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        // let the compare unit take the last word
        state_next = S_SWAP_LAST;
      end
      S_SWAP_LAST: begin
        if (best_idx == last_idx) begin
          state_next = S_FINISH;
        end else begin
          wr_en      = 1'b1;
          wr_data    = best_ent;
          state_next = S_SWAP_BEST;
        end
      end
      S_SWAP_BEST: begin
        wr_en      = 1'b1;
        wr_addr    = best_idx;
        wr_data    = last_ent;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        // hold until the output register is free
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      fill    <= '0;
      smp_vld <= 1'b0;
    end else begin
      state   <= state_next;
      fill    <= fill_next;
      smp_vld <= (state == S_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    cnt      <= cnt_next;
    smp_idx  <= cnt;
    smp_last <= (cnt == last_idx);
    if (res_load_acc) begin
      new_ent.tag   <= s_tdata[8:0];
      new_ent.count <= s_tdata[40:9];
      res_ent       <= '0;
      if (s_tuser[0] == ACT_INSERT) begin
        res_status <= (fill == FILL_W'(DEPTH)) ? STAT_FULL : STAT_OK;
      end else begin
        res_status <= (fill == '0) ? STAT_EMPTY : STAT_OK;
      end
    end
    if (res_load_pop) begin
      res_ent <= rd_data;
    end
  end

  assign smp = '{vld: smp_vld, is_last: smp_last, idx: smp_idx, ent: rd_data};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_tag    <= res_ent.tag;
      o_count  <= res_ent.count;
      o_occ    <= OCC_W'(fill);
      o_empty  <= (fill == '0);
      o_status <= res_status;
    end
  end

  assign m_tdata = {5'b0, o_empty, o_occ, o_count, o_tag};
  assign m_tuser = o_status;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(DEPTH))
    else $error("fill level above depth");

  a_wr_in_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> ({1'b0, wr_addr} < {1'b0, fill}))
    else $error("store write outside occupied slots");

  a_swap_below_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWAP_BEST) |-> (best_idx < last_idx))
    else $error("swap partner not below last slot");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (in_acc && s_tuser[0] == ACT_INSERT && fill != FILL_W'(DEPTH))
      |=> (fill == $past(fill) + FILL_W'(1)))
    else $error("insert did not grow the queue");

  a_empty_pop_holds: assert property (@(posedge clk) disable iff (rst)
    (in_acc && s_tuser[0] == ACT_POP && fill == '0) |=> (fill == '0))
    else $error("pop on empty queue changed fill level");
`endif

endmodule

// ===== rtl/core/mcpq_store.sv =====
// Entry store: DEPTH words of tag and count, one write and one registered read port.
// Depends on mcpq_pkg.
`timescale 1ns / 1ps

module mcpq_store
  import mcpq_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_t           wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/mcpq_min_unit.sv =====
// Running-minimum compare unit: one stored word per cycle against the best so far.
// Depends on mcpq_pkg; fed by the scan sequencer in the top level.
`timescale 1ns / 1ps

module mcpq_min_unit
  import mcpq_pkg::*;
(
  input  logic             clk,
  input  scan_smp_t        smp,
  output logic [IDX_W-1:0] best_idx,
  output entry_t           best_ent,
  output entry_t           last_ent
);

  logic take;

  // Strict less-than keeps the lowest index on equal counts
  assign take = smp.vld && ((smp.idx == '0) || (smp.ent.count < best_ent.count));

  always_ff @(posedge clk) begin
    if (take) begin
      best_idx <= smp.idx;
      best_ent <= smp.ent;
    end
    if (smp.vld && smp.is_last) begin
      last_ent <= smp.ent;
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for min_count_priority_queue: random and directed insert/pop
// words on the stream ports, checked against a behavioral queue model. Uses mcpq_pkg.
`timescale 1ns / 1ps

module testbench;
  import mcpq_pkg::*;

  localparam int CYCLE_LIMIT  = 3000000;
  localparam int RANDOM_WORDS = 850;
  localparam int DRAIN_CYCLES = 300;

  typedef struct packed {
    status_t            status;
    logic [TAG_W-1:0]   tag;
    logic [COUNT_W-1:0] count;
    logic [OCC_W-1:0]   occupancy;
    logic               now_empty;
  } pq_result_t;

  // Behavioral copy of the queue plus the results it still owes
  class pq_tracker;
    logic [TAG_W-1:0]   tags[DEPTH];
    logic [COUNT_W-1:0] counts[DEPTH];
    int                 fill;
    pq_result_t         owed[$];
    int                 mismatches;

    function new();
      fill = 0;
      mismatches = 0;
    endfunction

    // Swap the smallest count (lowest index on ties) into the last occupied slot
    function void settle();
      int best;
      logic [TAG_W-1:0]   t;
      logic [COUNT_W-1:0] c;
      best = 0;
      if (fill == 0) return;
      for (int i = 1; i < fill; i++)
        if (counts[i] < counts[best]) best = i;
      if (best != fill - 1) begin
        t = tags[fill-1];
        c = counts[fill-1];
        tags[fill-1] = tags[best];
        counts[fill-1] = counts[best];
        tags[best] = t;
        counts[best] = c;
      end
    endfunction

    function void accept_op(logic act, logic [TAG_W-1:0] tag, logic [COUNT_W-1:0] cnt);
      pq_result_t r;
      r = '{status: STAT_OK, tag: '0, count: '0, occupancy: '0, now_empty: 1'b0};
      if (act == ACT_INSERT) begin
        if (fill >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          tags[fill] = tag;
          counts[fill] = cnt;
          fill++;
          settle();
        end
      end else begin
        if (fill == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          fill--;
          r.tag = tags[fill];
          r.count = counts[fill];
          settle();
        end
      end
      r.occupancy = fill[OCC_W-1:0];
      r.now_empty = (fill == 0);
      owed.push_back(r);
    endfunction

    function void compare_result(pq_result_t got);
      pq_result_t want;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: status %0d tag %0d count %0d occ %0d empty %0b",
                   got.status, got.tag, got.count, got.occupancy, got.now_empty);
        return;
      end
      want = owed.pop_front();
      if (got.status != want.status || got.tag != want.tag || got.count != want.count ||
          got.occupancy != want.occupancy || got.now_empty != want.now_empty) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected status %0d tag %0d count %0d occ %0d empty %0b, got status %0d tag %0d count %0d occ %0d empty %0b",
                   want.status, want.tag, want.count, want.occupancy, want.now_empty,
                   got.status, got.tag, got.count, got.occupancy, got.now_empty);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic [0:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;
  logic [1:0]  m_tuser;

  pq_tracker tracker = new();
  int        cycles = 0;
  bit        send_steady = 0;
  bit        take_steady = 0;

  min_count_priority_queue dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Draw a gap; now and then switch into or out of a stretch with no gaps
  function automatic int draw_gap(ref bit steady);
    if ($urandom_range(0, 15) == 0) steady = !steady;
    return steady ? 0 : $urandom_range(0, 17);
  endfunction

  task automatic send_op(logic act, logic [TAG_W-1:0] tag, logic [COUNT_W-1:0] cnt);
    int gap;
    gap = draw_gap(send_steady);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, cnt, tag};
    s_tuser  <= act;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.accept_op(act, tag, cnt);
  endtask

  task automatic wait_results();
    while (tracker.owed.size() != 0) @(posedge clk);
  endtask

  task automatic send_random(logic act);
    logic [COUNT_W-1:0] cnt;
    // half the counts come from a narrow range so ties are common
    cnt = $urandom_range(0, 1) ? COUNT_W'($urandom_range(0, 15)) : COUNT_W'($urandom);
    send_op(act, TAG_W'($urandom_range(0, 511)), cnt);
  endtask

  // Result side: random hold-off, then take one word
  initial begin
    int gap;
    m_tready <= 1'b0;
    @(negedge rst);
    forever begin
      gap = draw_gap(take_steady);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      tracker.compare_result('{status: status_t'(m_tuser), tag: m_tdata[8:0],
                               count: m_tdata[40:9], occupancy: m_tdata[49:41],
                               now_empty: m_tdata[50]});
    end
  end

  initial begin
    bit filling;
    int refused;
    int pct;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= ACT_INSERT;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty pop, field extremes, alternating bit patterns, tied counts
    send_op(ACT_POP, 9'd0, 32'd0);
    send_op(ACT_INSERT, 9'd0, 32'hFFFF_FFFF);
    send_op(ACT_INSERT, 9'd511, 32'd0);
    send_op(ACT_INSERT, 9'h155, 32'hAAAA_AAAA);
    send_op(ACT_INSERT, 9'h0AA, 32'h5555_5555);
    send_op(ACT_INSERT, 9'd5, 32'd7);
    send_op(ACT_INSERT, 9'd6, 32'd7);
    send_op(ACT_INSERT, 9'd7, 32'd7);
    send_op(ACT_POP, 9'h1FF, 32'hFFFF_FFFF);
    send_op(ACT_INSERT, 9'd8, 32'd7);
    repeat (9) send_op(ACT_POP, 9'd0, 32'd0);

    // Random: sweep between full and empty, refusals included at each end
    filling = 1;
    refused = 0;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS / 2) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait_results();
      end
      if (filling && tracker.fill == DEPTH && refused >= 3) begin
        filling = 0;
        refused = 0;
      end else if (!filling && tracker.fill == 0 && refused >= 3) begin
        filling = 1;
        refused = 0;
      end
      pct = $urandom_range(0, 99);
      if ((filling && pct < 85) || (!filling && pct >= 85)) begin
        if (tracker.fill == DEPTH) refused++;
        send_random(ACT_INSERT);
      end else begin
        if (tracker.fill == 0) refused++;
        send_random(ACT_POP);
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.owed.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
